>>> hw/rtl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg: shared types and constants of the text-mode console writer
// Operation codes, control characters, register indexes and the command
// record that travels from the front end to the executor.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	// field widths
	localparam int OP_W        = 2;
	localparam int CHAR_W      = 8;
	localparam int INDEX_W     = 11;
	localparam int POS_W       = 11;
	localparam int CELL_W      = 16;
	localparam int ATTR_W      = 8;
	localparam int CFG_DATA_W  = 4;
	localparam int CFG_INDEX_W = 1;

	// command queue depth, a power of two
	localparam int QUEUE_DEPTH = 2;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'd1;

	localparam logic [CFG_DATA_W-1:0] FG_RESET = 4'd7;
	localparam logic [CFG_DATA_W-1:0] BG_RESET = 4'd0;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_BS,
		CMD_TAB,
		CMD_CR,
		CMD_LF,
		CMD_PRINT,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [CHAR_W-1:0]  chr;
		logic [INDEX_W-1:0] index;
		logic               in_range;
	} cmd_t;

	typedef struct packed {
		logic init;
		logic idle;
	} back_stat_t;

endpackage

>>> hw/rtl/text_mode_console_writer_top.sv
// Text-mode console writer: keeps a ROWS x COLUMNS screen of 16-bit cells
// (attribute high byte, character low byte) and a cursor, and returns one
// result per request with the cursor's linear position and, for a read, the
// cell. Requests enter a two-entry queue, so the input side keeps taking
// requests while the executor is busy. In the executor a read passes through a
// separate read step, a put that runs past the last row adds a scroll sweep
// over the screen memory, and a clear writes blanks to every cell; the screen
// memory has one write and one read port. After reset the memory is swept to
// zero with in_ready low; configuration writes are taken during that time.
// ----------------------------------------------------------------------------
// text_mode_console_writer_top: text-mode console writer
// Attribute registers, request front end and command executor.
// ----------------------------------------------------------------------------
module text_mode_console_writer_top #(
	parameter int COLUMNS  = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tmcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tmcw_pkg::TAB_STOP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tmcw_pkg::OP_W-1:0]        op,
	input  logic [tmcw_pkg::CHAR_W-1:0]      char_code,
	input  logic [tmcw_pkg::INDEX_W-1:0]     cell_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tmcw_pkg::POS_W-1:0]       cursor_position,
	output logic [tmcw_pkg::CELL_W-1:0]      cell_value,
	input  logic                             cfg_we,
	input  logic [tmcw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tmcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CELL_COUNT = COLUMNS * ROWS;

	logic [tmcw_pkg::CFG_DATA_W-1:0] fg_q;
	logic [tmcw_pkg::CFG_DATA_W-1:0] bg_q;
	logic                            cmd_valid;
	tmcw_pkg::cmd_t                  cmd;
	logic                            pop;
	tmcw_pkg::back_stat_t            stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tmcw_pkg::FG_RESET;
			bg_q <= tmcw_pkg::BG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tmcw_pkg::CFG_FOREGROUND: fg_q <= cfg_data;
				tmcw_pkg::CFG_BACKGROUND: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tmcw_front #(
		.CELL_COUNT(CELL_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.char_code (char_code),
		.cell_index(cell_index),
		.hold      (stat.init),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop)
	);

	tmcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.TAB_STOP(TAB_STOP)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.pop            (pop),
		.attr           ({bg_q, fg_q}),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cursor_position(cursor_position),
		.cell_value     (cell_value)
	);

`ifndef SYNTHESIS
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (stat.idle && cmd_valid))
		else $error("executor took a command while busy or from an empty queue");

	a_no_intake_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		stat.init |-> !in_ready)
		else $error("request taken during the memory clearing pass");

	a_pos_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CELL_COUNT > 2048 || int'(cursor_position) < CELL_COUNT))
		else $error("cursor position outside the screen");
`endif

endmodule

>>> hw/rtl/tmcw_front.sv
// ----------------------------------------------------------------------------
// tmcw_front: request intake and classification
// Decodes each request into a command kind and holds it in a short queue
// until the executor takes it.
// ----------------------------------------------------------------------------
module tmcw_front #(
	parameter int CELL_COUNT = tmcw_pkg::COLUMNS_DEF * tmcw_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tmcw_pkg::OP_W-1:0]    op,
	input  logic [tmcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tmcw_pkg::INDEX_W-1:0] cell_index,
	input  logic                         hold,
	output logic                         cmd_valid,
	output tmcw_pkg::cmd_t               cmd,
	input  logic                         pop
);

	localparam int PTR_W = $clog2(tmcw_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(tmcw_pkg::QUEUE_DEPTH + 1);

	tmcw_pkg::cmd_t   new_cmd;
	tmcw_pkg::cmd_t   q_mem [tmcw_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	always_comb begin
		new_cmd.chr      = char_code;
		new_cmd.index    = cell_index;
		new_cmd.in_range = int'(cell_index) < CELL_COUNT;
		case (op)
			tmcw_pkg::OP_PUT: begin
				case (char_code)
					tmcw_pkg::CH_BS:  new_cmd.kind = tmcw_pkg::CMD_BS;
					tmcw_pkg::CH_TAB: new_cmd.kind = tmcw_pkg::CMD_TAB;
					tmcw_pkg::CH_CR:  new_cmd.kind = tmcw_pkg::CMD_CR;
					tmcw_pkg::CH_LF:  new_cmd.kind = tmcw_pkg::CMD_LF;
					// remaining control bytes do nothing
					default: new_cmd.kind = (char_code >= tmcw_pkg::CH_SPACE) ?
						tmcw_pkg::CMD_PRINT : tmcw_pkg::CMD_NOP;
				endcase
			end
			tmcw_pkg::OP_CLEAR: new_cmd.kind = tmcw_pkg::CMD_CLEAR;
			tmcw_pkg::OP_READ:  new_cmd.kind = tmcw_pkg::CMD_READ;
			default:            new_cmd.kind = tmcw_pkg::CMD_NOP;
		endcase
	end

	assign in_ready  = (count_q != CNT_W'(tmcw_pkg::QUEUE_DEPTH)) && !hold;
	assign push      = in_valid && in_ready;
	assign cmd_valid = count_q != '0;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/tmcw_back.sv
// ----------------------------------------------------------------------------
// tmcw_back: command executor
// Owns the cursor and the screen memory, runs scroll and fill sweeps and
// holds the result register.
// ----------------------------------------------------------------------------
module tmcw_back #(
	parameter int COLUMNS  = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tmcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tmcw_pkg::TAB_STOP_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  tmcw_pkg::cmd_t              cmd,
	output logic                        pop,
	input  logic [tmcw_pkg::ATTR_W-1:0] attr,
	output tmcw_pkg::back_stat_t        stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tmcw_pkg::POS_W-1:0]  cursor_position,
	output logic [tmcw_pkg::CELL_W-1:0] cell_value
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int MOVE_N     = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int CN_W       = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int RN_W       = $clog2(ROWS + 1);
	localparam int PH_W       = $clog2(TAB_STOP);
	localparam int CELL_W     = tmcw_pkg::CELL_W;
	localparam int POS_W      = tmcw_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL
	} state_t;

	state_t            state_q;
	logic              init_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [PH_W-1:0]   ph_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [CELL_W-1:0] fill_q;
	logic              rd_ok_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic [CELL_W-1:0] cell_q;
	logic [CELL_W-1:0] rdata_q;
	logic [CELL_W-1:0] mem [CELL_COUNT];

	logic [CN_W-1:0]   col_n;
	logic [RN_W-1:0]   row_n;
	logic [PH_W-1:0]   ph_n;
	logic              scroll_n;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] new_pos;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [ADDR_W-1:0] mem_ra;
	logic [CELL_W-1:0] mem_wd;
	logic              out_set;

	// ph_q tracks the column modulo the tab stop
	always_comb begin
		col_n = CN_W'(col_q);
		row_n = RN_W'(row_q);
		ph_n  = ph_q;
		case (cmd.kind)
			tmcw_pkg::CMD_BS: begin
				if (col_q != '0) begin
					col_n = CN_W'(col_q) - CN_W'(1);
					ph_n  = (ph_q == '0) ? PH_W'(TAB_STOP - 1) : ph_q - PH_W'(1);
				end
			end
			tmcw_pkg::CMD_TAB: begin
				col_n = CN_W'(col_q) + CN_W'(TAB_STOP) - CN_W'(ph_q);
				ph_n  = '0;
			end
			tmcw_pkg::CMD_CR: begin
				col_n = '0;
				ph_n  = '0;
			end
			tmcw_pkg::CMD_LF: begin
				col_n = '0;
				row_n = row_n + RN_W'(1);
				ph_n  = '0;
			end
			tmcw_pkg::CMD_PRINT: begin
				col_n = CN_W'(col_q) + CN_W'(1);
				ph_n  = (ph_q == PH_W'(TAB_STOP - 1)) ? '0 : ph_q + PH_W'(1);
			end
			default: ;
		endcase
		// wrap past the last column
		if (col_n >= CN_W'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + RN_W'(1);
			ph_n  = '0;
		end
		scroll_n = row_n >= RN_W'(ROWS);
		if (scroll_n) begin
			row_n = RN_W'(ROWS - 1);
		end
	end

	assign cur_addr = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));
	assign new_pos  = ADDR_W'(int'(row_n) * COLUMNS + int'(col_n));

	assign pop = (state_q == ST_IDLE) && cmd_valid && (!out_valid_q || out_ready);

	// a new result is loaded by every popped command except a read, and by the read step
	assign out_set = (pop && cmd.kind != tmcw_pkg::CMD_READ) || (state_q == ST_READ);

	// scroll: read one row ahead, then write the registered read data
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_addr;
		mem_wd = fill_q;
		mem_ra = ADDR_W'(cmd.index);
		case (state_q)
			ST_IDLE: begin
				if (pop && cmd.kind == tmcw_pkg::CMD_PRINT) begin
					mem_we = 1'b1;
					mem_wd = {attr, cmd.chr};
				end
			end
			ST_SCROLL: begin
				mem_ra = ADDR_W'(int'(cnt_q) + COLUMNS);
				mem_we = cnt_q != '0;
				mem_wa = cnt_q - ADDR_W'(1);
				mem_wd = rdata_q;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			init_q      <= 1'b1;
			col_q       <= '0;
			row_q       <= '0;
			ph_q        <= '0;
			cnt_q       <= '0;
			fill_q      <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			cell_q      <= '0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (cmd.kind)
							tmcw_pkg::CMD_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								ph_q    <= '0;
								pos_q   <= '0;
								cell_q  <= '0;
								fill_q  <= {attr, tmcw_pkg::CH_SPACE};
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							tmcw_pkg::CMD_READ: begin
								rd_ok_q <= cmd.in_range;
								state_q <= ST_READ;
							end
							default: begin
								col_q  <= COL_W'(col_n);
								row_q  <= ROW_W'(row_n);
								ph_q   <= ph_n;
								pos_q  <= POS_W'(new_pos);
								cell_q <= '0;
								if (scroll_n) begin
									cnt_q   <= '0;
									state_q <= ST_SCROLL;
								end
							end
						endcase
					end
				end
				ST_READ: begin
					pos_q   <= POS_W'(cur_addr);
					cell_q  <= rd_ok_q ? rdata_q : '0;
					state_q <= ST_IDLE;
				end
				ST_SCROLL: begin
					if (cnt_q == ADDR_W'(MOVE_N)) begin
						// bottom row gets blanks from here on
						fill_q  <= {attr, tmcw_pkg::CH_SPACE};
						state_q <= ST_FILL;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_FILL: begin
					if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.init       = init_q;
	assign stat.idle       = state_q == ST_IDLE;
	assign out_valid       = out_valid_q;
	assign cursor_position = pos_q;
	assign cell_value      = cell_q;

endmodule
